// ===== rtl/arpat_pkg.sv =====
// ----------------------------------------------------------------------------
// arpat_pkg
// Shared types and constants for the ARP address table: the search beat that
// runs down the row of table cells, and the sequencer states.
// ----------------------------------------------------------------------------
package arpat_pkg;

  localparam int unsigned IP_W         = 32;
  localparam int unsigned MAC_W        = 48;
  localparam int unsigned DEPTH_DFLT   = 16;

  // item kinds
  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_LOOKUP = 1'b1;

  // search beat handed from cell to cell
  typedef struct packed {
    logic             vld;
    logic             hit;
    logic [IP_W-1:0]  key;
    logic [MAC_W-1:0] mac;
  } srch_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_DONE
  } state_t;

endpackage

// ===== rtl/arp_address_table_unit.sv =====
// ----------------------------------------------------------------------------
// arp_address_table_unit
// Address resolution table: appends IPv4/MAC pairs and looks up the oldest
// MAC stored for an IPv4 address.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) carries one item per beat: in_kind
//   selects insert (0) or lookup (1), with in_ip_addr and in_mac_addr.
//   Output channel (out_valid/out_stall) returns one result beat per item:
//   out_found, out_found_mac, out_insert_dropped.
//   Entries live in a row of TABLE_DEPTH cells. An insert writes the cell at
//   the fill count directly; a full table drops it and flags the result.
//   A lookup beat enters the first cell and moves one cell per cycle; the
//   oldest matching cell stamps its MAC on the beat.
//   An insert result is registered by the sequencer and then moved to the
//   output register; a lookup result is captured when its search beat
//   leaves the last cell of the row, then moved to the output register.
//   One item is in work at a time: a new item is taken as soon as the
//   previous result has moved to the output register, even while that
//   register waits on out_stall.
//   Reset empties the table (fill count to zero) and clears both channels.
//   A stalled result holds on the output ports until taken.
// ----------------------------------------------------------------------------
module arp_address_table_unit #(
  parameter int unsigned TABLE_DEPTH = arpat_pkg::DEPTH_DFLT
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_kind,
  input  logic [arpat_pkg::IP_W-1:0]  in_ip_addr,
  input  logic [arpat_pkg::MAC_W-1:0] in_mac_addr,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_found,
  output logic [arpat_pkg::MAC_W-1:0] out_found_mac,
  output logic                        out_insert_dropped
);

  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);

  arpat_pkg::state_t state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;

  logic                        res_found_r, res_found_nxt;
  logic [arpat_pkg::MAC_W-1:0] res_mac_r, res_mac_nxt;
  logic                        res_drop_r, res_drop_nxt;

  logic                        out_valid_r, out_valid_nxt;
  logic                        out_found_r;
  logic [arpat_pkg::MAC_W-1:0] out_mac_r;
  logic                        out_drop_r;

  logic in_acc;
  logic ins_go;
  logic out_load;
  logic full;

  arpat_pkg::srch_t chain [0:TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] wr_en;

  assign in_stall = (state_r != arpat_pkg::ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign full     = (count_r == CNT_W'(TABLE_DEPTH));
  assign ins_go   = in_acc && (in_kind == arpat_pkg::KIND_INSERT) && !full;
  assign out_load = (state_r == arpat_pkg::ST_DONE) && (!out_valid_r || !out_stall);

  // search beat injected at the head of the row
  always_comb begin
    chain[0].vld = in_acc && (in_kind == arpat_pkg::KIND_LOOKUP);
    chain[0].hit = 1'b0;
    chain[0].key = in_ip_addr;
    chain[0].mac = '0;
  end

  // row of table cells
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    assign wr_en[i] = ins_go && (count_r == CNT_W'(i));

    arpat_cell #(
      .INDEX (i),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .wr_en    (wr_en[i]),
      .wr_ip    (in_ip_addr),
      .wr_mac   (in_mac_addr),
      .count    (count_r),
      .srch_in  (chain[i]),
      .srch_out (chain[i+1])
    );
  end

  // sequencer: next state, fill count and result capture
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    res_found_nxt = res_found_r;
    res_mac_nxt   = res_mac_r;
    res_drop_nxt  = res_drop_r;
    unique case (state_r)
      arpat_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (in_kind == arpat_pkg::KIND_INSERT) begin
            res_found_nxt = 1'b0;
            res_mac_nxt   = '0;
            res_drop_nxt  = full;
            if (!full) begin
              count_nxt = count_r + CNT_W'(1);
            end
            state_nxt = arpat_pkg::ST_DONE;
          end else begin
            state_nxt = arpat_pkg::ST_SEARCH;
          end
        end
      end
      arpat_pkg::ST_SEARCH: begin
        if (chain[TABLE_DEPTH].vld) begin
          res_found_nxt = chain[TABLE_DEPTH].hit;
          res_mac_nxt   = chain[TABLE_DEPTH].mac;
          res_drop_nxt  = 1'b0;
          state_nxt     = arpat_pkg::ST_DONE;
        end
      end
      arpat_pkg::ST_DONE: begin
        if (out_load) begin
          state_nxt = arpat_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = arpat_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= arpat_pkg::ST_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
    res_found_r <= res_found_nxt;
    res_mac_r   <= res_mac_nxt;
    res_drop_r  <= res_drop_nxt;
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    if (out_load) begin
      out_found_r <= res_found_r;
      out_mac_r   <= res_mac_r;
      out_drop_r  <= res_drop_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_found          = out_found_r;
  assign out_found_mac      = out_mac_r;
  assign out_insert_dropped = out_drop_r;

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(TABLE_DEPTH))
    else $error("fill count beyond table depth");

  a_tail_in_search: assert property (@(posedge clk) disable iff (!rst_n)
    chain[TABLE_DEPTH].vld |-> (state_r == arpat_pkg::ST_SEARCH))
    else $error("search beat left the row outside a lookup");

  a_drop_holds_count: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_kind == arpat_pkg::KIND_INSERT) && full) |=> full)
    else $error("dropped insert changed the fill count");

  a_insert_no_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_drop_r) |-> (!out_found_r && (out_mac_r == '0)))
    else $error("dropped insert reported a hit");

endmodule

// ===== rtl/arpat_cell.sv =====
// ----------------------------------------------------------------------------
// arpat_cell
// One table entry. Holds an address pair, and compares the passing search
// beat against it; the first occupied cell that matches marks the beat a hit.
// ----------------------------------------------------------------------------
module arpat_cell #(
  parameter int unsigned INDEX = 0,
  parameter int unsigned CNT_W = 5
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       wr_en,
  input  logic [arpat_pkg::IP_W-1:0] wr_ip,
  input  logic [arpat_pkg::MAC_W-1:0] wr_mac,
  input  logic [CNT_W-1:0]           count,
  input  arpat_pkg::srch_t           srch_in,
  output arpat_pkg::srch_t           srch_out
);

  logic [arpat_pkg::IP_W-1:0]  ip_r;
  logic [arpat_pkg::MAC_W-1:0] mac_r;
  arpat_pkg::srch_t            srch_r;
  arpat_pkg::srch_t            srch_nxt;
  logic                        occ;

  // entry is live only below the fill count
  assign occ = (CNT_W'(INDEX) < count);

  // entry storage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      ip_r  <= wr_ip;
      mac_r <= wr_mac;
    end
  end

  // compare and pass on
  always_comb begin
    srch_nxt = srch_in;
    if (srch_in.vld && !srch_in.hit && occ && (ip_r == srch_in.key)) begin
      srch_nxt.hit = 1'b1;
      srch_nxt.mac = mac_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      srch_r.vld <= 1'b0;
    end else begin
      srch_r.vld <= srch_nxt.vld;
    end
    srch_r.hit <= srch_nxt.hit;
    srch_r.key <= srch_nxt.key;
    srch_r.mac <= srch_nxt.mac;
  end

  assign srch_out = srch_r;

endmodule
